>>> design/cfbs_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 framed byte stuffer package
// Shared constants, the command record passed from the front end to the
// back end, and the CRC-16/ARC byte update.
// ----------------------------------------------------------------------------
package cfbs_pkg;

   localparam logic [7:0] PRE_BYTE  = 8'hA5;  // preamble byte
   localparam logic [7:0] ESC_A     = 8'hA6;  // escape lead for A5 and A6
   localparam logic [7:0] END_BYTE  = 8'h5A;  // closing byte of a frame
   localparam logic [7:0] ESC_B     = 8'h5B;  // escape lead for 5A and 5B
   localparam logic [7:0] TAIL_TWO  = 8'h02;  // tail for A5 and 5A
   localparam logic [7:0] TAIL_ONE  = 8'h01;  // tail for A6 and 5B

   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int PRE_W = 5;
   localparam logic [PRE_W-1:0] MAX_PREAMBLE   = 5'd16;
   localparam logic [PRE_W-1:0] RESET_PREAMBLE = 5'd8;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   // One accepted request, already classified by the front end.
   typedef struct packed {
      logic [7:0]       data;      // raw payload byte
      logic             last;      // final payload byte of the frame
      logic [PRE_W-1:0] pre_count; // preamble bytes to send first
      logic [15:0]      crc;       // CRC after this byte
   } cmd_type;

   // Reflected CRC-16 update over one byte.
   function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                              input logic [7:0]  b);
      logic [15:0] c;
      c = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> design/cfbs_front.sv
// ----------------------------------------------------------------------------
// CRC-16 framed byte stuffer front end
// Holds the frame state, the running CRC and the preamble register, and
// turns each accepted request into a command for the back end.
// ----------------------------------------------------------------------------
module cfbs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [cfbs_pkg::PRE_W-1:0] csr_wr_data,
   input  logic                      accept,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output cfbs_pkg::cmd_type         cmd
);

   logic [cfbs_pkg::PRE_W-1:0] preamble_ff, preamble_in;
   logic                       in_frame_ff, in_frame_in;
   logic [15:0]                crc_ff, crc_in;
   logic [cfbs_pkg::PRE_W-1:0] pre_sat;
   logic [15:0]                crc_next;

   always_comb begin
      pre_sat = (preamble_ff > cfbs_pkg::MAX_PREAMBLE) ? cfbs_pkg::MAX_PREAMBLE
                                                       : preamble_ff;
      // A new frame restarts the CRC from zero.
      crc_next = cfbs_pkg::crc_update(in_frame_ff ? crc_ff : 16'h0000, data_byte);

      cmd.data      = data_byte;
      cmd.last      = last_byte;
      cmd.pre_count = in_frame_ff ? '0 : pre_sat;
      cmd.crc       = crc_next;

      preamble_in = csr_wr_en ? csr_wr_data : preamble_ff;
      in_frame_in = in_frame_ff;
      crc_in      = crc_ff;
      if (accept) begin
         in_frame_in = !last_byte;
         crc_in      = last_byte ? 16'h0000 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= cfbs_pkg::RESET_PREAMBLE;
         in_frame_ff <= 1'b0;
         crc_ff      <= 16'h0000;
      end else begin
         preamble_ff <= preamble_in;
         in_frame_ff <= in_frame_in;
         crc_ff      <= crc_in;
      end
   end

endmodule

>>> design/cfbs_queue.sv
// ----------------------------------------------------------------------------
// CRC-16 framed byte stuffer command queue
// Small register queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module cfbs_queue #(
   parameter int DEPTH = cfbs_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cfbs_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              pop,
   output cfbs_pkg::cmd_type head,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfbs_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      full    = (count_ff == CNT_W'(DEPTH));
      empty   = (count_ff == '0);
      head    = mem_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

>>> design/cfbs_back.sv
// ----------------------------------------------------------------------------
// CRC-16 framed byte stuffer back end
// Expands the command at the head of the queue into preamble, stuffed
// payload, stuffed CRC and end bytes, one byte per cycle into the output
// register whenever that register is empty or being popped.
// ----------------------------------------------------------------------------
module cfbs_back (
   input  logic              clock,
   input  logic              reset,
   input  cfbs_pkg::cmd_type head,
   input  logic              head_valid,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_frame_end
);

   typedef enum logic [2:0] {
      PH_PRE,
      PH_DATA,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_END
   } phase_type;

   phase_type                  phase_ff, phase_in, cur_phase;
   logic [cfbs_pkg::PRE_W-1:0] cnt_ff, cnt_in;
   logic                       second_ff, second_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       run_last_ff, run_last_in;
   logic                       frame_end_ff, frame_end_in;

   logic       go, done, step;
   logic [7:0] sbyte, lead, tail;
   logic       needs_esc;

   always_comb begin
      go = head_valid && (!out_valid_ff || rsp_pop);

      // Once the preamble is complete the payload starts in the same cycle.
      cur_phase = phase_ff;
      if (phase_ff == PH_PRE && cnt_ff == head.pre_count) begin
         cur_phase = PH_DATA;
      end

      case (cur_phase)
         PH_CRC_LO: sbyte = head.crc[7:0];
         PH_CRC_HI: sbyte = head.crc[15:8];
         default:   sbyte = head.data;
      endcase

      needs_esc = (sbyte == cfbs_pkg::PRE_BYTE) || (sbyte == cfbs_pkg::ESC_A) ||
                  (sbyte == cfbs_pkg::END_BYTE) || (sbyte == cfbs_pkg::ESC_B);
      lead = (sbyte == cfbs_pkg::PRE_BYTE || sbyte == cfbs_pkg::ESC_A)
             ? cfbs_pkg::ESC_A : cfbs_pkg::ESC_B;
      tail = (sbyte == cfbs_pkg::PRE_BYTE || sbyte == cfbs_pkg::END_BYTE)
             ? cfbs_pkg::TAIL_TWO : cfbs_pkg::TAIL_ONE;

      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      second_in    = second_ff;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      done         = 1'b0;
      step         = 1'b0;

      if (go) begin
         run_last_in  = 1'b0;
         frame_end_in = 1'b0;
         case (cur_phase)
            PH_PRE: begin
               out_byte_in = cfbs_pkg::PRE_BYTE;
               cnt_in      = cnt_ff + cfbs_pkg::PRE_W'(1);
            end
            PH_END: begin
               out_byte_in  = cfbs_pkg::END_BYTE;
               run_last_in  = 1'b1;
               frame_end_in = 1'b1;
               done         = 1'b1;
            end
            default: begin
               if (needs_esc && !second_ff) begin
                  out_byte_in = lead;
                  second_in   = 1'b1;
                  phase_in    = cur_phase;
               end else begin
                  out_byte_in = second_ff ? tail : sbyte;
                  second_in   = 1'b0;
                  step        = 1'b1;
               end
            end
         endcase

         if (step) begin
            case (cur_phase)
               PH_DATA: begin
                  if (head.last) begin
                     phase_in = PH_CRC_LO;
                  end else begin
                     run_last_in = 1'b1;
                     done        = 1'b1;
                  end
               end
               PH_CRC_LO: phase_in = PH_CRC_HI;
               default:   phase_in = PH_END;
            endcase
         end

         if (done) begin
            phase_in  = PH_PRE;
            cnt_in    = '0;
            second_in = 1'b0;
         end
      end

      head_pop = done;

      out_valid_in = out_valid_ff;
      if (go) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      rsp_empty     = !out_valid_ff;
      rsp_out_byte  = out_byte_ff;
      rsp_run_last  = run_last_ff;
      rsp_frame_end = frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PRE;
         cnt_ff       <= '0;
         second_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff  <= out_byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

endmodule

>>> design/crc16_framed_byte_stuffer.sv
// ----------------------------------------------------------------------------
// CRC-16 framed byte stuffer
// Frames a serialized packet for a byte-oriented serial line: preamble,
// byte-stuffed payload, stuffed CRC-16/ARC (low byte first) and end byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_push / req_full    req_data_byte, req_last_byte
//   rsp_      out        rsp_pop / rsp_empty    rsp_out_byte, rsp_run_last,
//                                               rsp_frame_end
//   csr_      in         csr_wr_en              csr_wr_data (preamble count)
//
// The back end sends one output byte per cycle when the consumer keeps up.
// A request expands to its byte or, for an escaped byte, a lead and a tail,
// plus the preamble on a frame's first byte and the CRC and end bytes on its
// last; the back end's byte sequencer produces this run.
// The front end takes a new request every cycle until the command queue fills.
// Reset is synchronous and needs no clearing pass; the block is ready in the
// first cycle after reset. A stalled consumer holds the output register and,
// once the queue is full, raises req_full.
//
module crc16_framed_byte_stuffer #(
   parameter int QUEUE_DEPTH = cfbs_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_run_last,
   output logic                       rsp_frame_end,
   input  logic                       csr_wr_en,
   input  logic [cfbs_pkg::PRE_W-1:0] csr_wr_data
);

   cfbs_pkg::cmd_type front_cmd;
   cfbs_pkg::cmd_type head_cmd;
   logic              q_full, q_empty, q_pop;
   logic              accept;

   // A request is accepted whenever the command queue has room.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // The front end tracks the frame and CRC and classifies each request.
   cfbs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .cmd         (front_cmd)
   );

   // The queue lets the front end run ahead while the back end expands bytes.
   cfbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .wr_cmd (front_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .head   (head_cmd),
      .empty  (q_empty)
   );

   // The back end turns each command into its run of line bytes.
   cfbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head_cmd),
      .head_valid    (!q_empty),
      .head_pop      (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

   // The closing byte of a frame is always 5A and always ends its request.
   a_frame_end_byte : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> (rsp_run_last &&
                                         rsp_out_byte == cfbs_pkg::END_BYTE))
      else $error("frame end without closing byte");

   // The back end retires a command only when one is waiting.
   a_pop_needs_cmd : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command retired from an empty queue");

   // Reset leaves the block empty and ready.
   a_reset_state : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full && q_empty))
      else $error("block not idle after reset");

endmodule
